// ----- hw/rtl/lscr_pkg.sv -----
// shared types and constants for the log scale colour ramp
`timescale 1ns / 1ps
`default_nettype none
package lscr_pkg;

  localparam int SIGMA_WIDTH   = 32;
  localparam int CFG_W         = 32;
  localparam int PX_W          = 32;
  localparam int RGB_W         = 24;
  localparam int LOG_FRAC_BITS = 24;
  localparam int MANT_W        = 32;
  localparam int LOG_LATENCY   = LOG_FRAC_BITS + 2;

  typedef enum logic [2:0] {
    REG_SCALE_USABLE = 3'd0,
    REG_LOW_PX       = 3'd1,
    REG_HIGH_PX      = 3'd2,
    REG_STOP_START   = 3'd3,
    REG_STOP_MIDDLE  = 3'd4,
    REG_STOP_END     = 3'd5,
    REG_ABSENT_RGB   = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [SIGMA_WIDTH-1:0] sigma;
    logic                   sigma_valid;
  } request_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       absent;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lscr_log2.sv -----
// pipelined base-2 logarithm, integer part plus truncated fraction by repeated squaring
`timescale 1ns / 1ps
`default_nettype none
module lscr_log2 import lscr_pkg::*; #(
  parameter int IN_W = 32
) (
  input  logic                                    clk,
  input  logic [IN_W-1:0]                         x,
  output logic [$clog2(IN_W)+LOG_FRAC_BITS-1:0]   log_val
);

  localparam int TOP_W = $clog2(IN_W);

  logic [IN_W-1:0]      x_a;
  logic [TOP_W-1:0]     top_a;
  logic [TOP_W-1:0]     top_comb;
  logic [IN_W+30:0]     wide;
  logic [MANT_W-1:0]    m_s    [0:LOG_FRAC_BITS];
  logic [TOP_W-1:0]     top_s  [0:LOG_FRAC_BITS];
  logic [LOG_FRAC_BITS-1:0] frac_s [0:LOG_FRAC_BITS];

  // highest set bit
  always_comb begin
    top_comb = '0;
    for (int i = 1; i < IN_W; i++) begin
      if (x[i]) begin
        top_comb = TOP_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_a   <= x;
    top_a <= top_comb;
  end

  assign wide = {x_a, 31'b0} >> top_a;

  always_ff @(posedge clk) begin
    m_s[0]    <= wide[MANT_W-1:0];
    top_s[0]  <= top_a;
    frac_s[0] <= '0;
  end

  for (genvar i = 1; i <= LOG_FRAC_BITS; i++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     p;
    assign sq = m_s[i-1] * m_s[i-1];
    assign p  = sq[2*MANT_W-1:MANT_W-1];
    always_ff @(posedge clk) begin
      m_s[i]    <= p[MANT_W] ? p[MANT_W:1] : p[MANT_W-1:0];
      frac_s[i] <= {frac_s[i-1][LOG_FRAC_BITS-2:0], p[MANT_W]};
      top_s[i]  <= top_s[i-1];
    end
  end

  assign log_val = {top_s[LOG_FRAC_BITS], frac_s[LOG_FRAC_BITS]};

endmodule
`default_nettype wire

// ----- hw/rtl/log_scale_colour_ramp.sv -----
// top level: noise value to rgb colour over a logarithmic three-stop ramp
//
// One request is taken every clock and its result is strobed by result_valid for
// one cycle; busy is always low. The result passes through the logarithm pipeline
// (one squaring multiplier stage per fraction bit, 24 stages) and the position
// divider (one quotient bit per stage). Registers may only be written while no
// request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module log_scale_colour_ramp import lscr_pkg::*; #(
  parameter int POSITION_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  request_t         request,
  output logic             result_valid,
  output result_t          result,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [CFG_W-1:0] wr_data
);

  localparam int PF     = POSITION_FRAC_BITS;
  localparam int SIG_LW = $clog2(SIGMA_WIDTH) + LOG_FRAC_BITS;
  localparam int PX_LW  = $clog2(PX_W) + LOG_FRAC_BITS;
  localparam int LW     = (SIG_LW > PX_LW) ? SIG_LW : PX_LW;
  localparam int NW     = LW + PF + 2;
  localparam int PW     = 9 + PF + 2;
  localparam int AW     = PF + 11;

  logic             scale_usable;
  logic [PX_W-1:0]  low_px;
  logic [PX_W-1:0]  high_px;
  logic [RGB_W-1:0] stop_start_rgb;
  logic [RGB_W-1:0] stop_middle_rgb;
  logic [RGB_W-1:0] stop_end_rgb;
  logic [RGB_W-1:0] absent_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_usable    <= 1'b0;
      low_px          <= PX_W'(1048576);
      high_px         <= PX_W'(1048576);
      stop_start_rgb  <= '0;
      stop_middle_rgb <= '0;
      stop_end_rgb    <= '0;
      absent_rgb      <= RGB_W'(8421504);
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_SCALE_USABLE: scale_usable    <= wr_data[0];
        REG_LOW_PX:       low_px          <= wr_data[PX_W-1:0];
        REG_HIGH_PX:      high_px         <= wr_data[PX_W-1:0];
        REG_STOP_START:   stop_start_rgb  <= wr_data[RGB_W-1:0];
        REG_STOP_MIDDLE:  stop_middle_rgb <= wr_data[RGB_W-1:0];
        REG_STOP_END:     stop_end_rgb    <= wr_data[RGB_W-1:0];
        REG_ABSENT_RGB:   absent_rgb      <= wr_data[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // entry stage
  logic                   v0;
  logic                   abs0;
  logic                   gt0;
  logic [SIGMA_WIDTH-1:0] sigma0;
  logic [PX_W-1:0]        low0;
  logic [PX_W-1:0]        high0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start & ~busy;
    end
    abs0   <= ~scale_usable | ~request.sigma_valid | (request.sigma == '0) | (low_px == '0);
    gt0    <= high_px > low_px;
    sigma0 <= request.sigma;
    low0   <= low_px;
    high0  <= high_px;
  end

  logic [SIG_LW-1:0] lv_raw;
  logic [PX_LW-1:0]  ll_raw;
  logic [PX_LW-1:0]  lh_raw;

  lscr_log2 #(.IN_W(SIGMA_WIDTH)) u_log_sigma (.clk(clk), .x(sigma0), .log_val(lv_raw));
  lscr_log2 #(.IN_W(PX_W))        u_log_low   (.clk(clk), .x(low0),   .log_val(ll_raw));
  lscr_log2 #(.IN_W(PX_W))        u_log_high  (.clk(clk), .x(high0),  .log_val(lh_raw));

  logic v_d   [0:LOG_LATENCY];
  logic abs_d [0:LOG_LATENCY];
  logic gt_d  [0:LOG_LATENCY];

  assign v_d[0]   = v0;
  assign abs_d[0] = abs0;
  assign gt_d[0]  = gt0;

  for (genvar k = 1; k <= LOG_LATENCY; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        v_d[k] <= 1'b0;
      end else begin
        v_d[k] <= v_d[k-1];
      end
      abs_d[k] <= abs_d[k-1];
      gt_d[k]  <= gt_d[k-1];
    end
  end

  // position setup
  logic [LW-1:0] lv;
  logic [LW-1:0] ll;
  logic [LW-1:0] lh;
  logic [LW-1:0] den;
  logic [LW-1:0] num;

  assign lv  = LW'(lv_raw);
  assign ll  = LW'(ll_raw);
  assign lh  = LW'(lh_raw);
  assign den = lh - ll;
  assign num = lv - ll;

  logic          v_q   [0:PF+1];
  logic          abs_q [0:PF+1];
  logic          zero_q[0:PF+1];
  logic          one_q [0:PF+1];
  logic [NW-1:0] r_q   [0:PF+1];
  logic [NW-1:0] d_q   [0:PF+1];
  logic [PF:0]   q_q   [0:PF+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= v_d[LOG_LATENCY];
    end
    abs_q[0]  <= abs_d[LOG_LATENCY];
    zero_q[0] <= ~gt_d[LOG_LATENCY] | (lv <= ll) | (den == '0);
    one_q[0]  <= num >= den;
    r_q[0]    <= (NW'(num) << (PF + 1)) + NW'(den);
    d_q[0]    <= NW'(den) << 1;
    q_q[0]    <= '0;
  end

  // one quotient bit per stage
  for (genvar j = 1; j <= PF + 1; j++) begin : g_div
    logic [NW-1:0] sub;
    logic          take;
    assign sub  = d_q[j-1] << (PF + 1 - j);
    assign take = r_q[j-1] >= sub;
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_q[j-1];
      end
      abs_q[j]  <= abs_q[j-1];
      zero_q[j] <= zero_q[j-1];
      one_q[j]  <= one_q[j-1];
      r_q[j]    <= take ? (r_q[j-1] - sub) : r_q[j-1];
      d_q[j]    <= d_q[j-1];
      q_q[j]    <= {q_q[j-1][PF-1:0], take};
    end
  end

  // segment select and channel products
  logic [PF:0]      pos;
  logic [PF+1:0]    t2;
  logic             upper;
  logic [PF:0]      local_t;
  logic [RGB_W-1:0] a_rgb;
  logic [RGB_W-1:0] b_rgb;

  always_comb begin
    if (zero_q[PF+1]) begin
      pos = '0;
    end else if (one_q[PF+1]) begin
      pos = (PF+1)'(1) << PF;
    end else begin
      pos = q_q[PF+1];
    end
    t2      = {pos, 1'b0};
    upper   = t2 >= ((PF+2)'(1) << PF);
    local_t = upper ? (PF+1)'(t2 - ((PF+2)'(1) << PF)) : (PF+1)'(t2);
    a_rgb   = upper ? stop_middle_rgb : stop_start_rgb;
    b_rgb   = upper ? stop_end_rgb    : stop_middle_rgb;
  end

  logic                 v_m;
  logic                 abs_m;
  logic [RGB_W-1:0]     a_m;
  logic signed [PW-1:0] prod_m [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_mul
    logic signed [8:0] diff;
    assign diff = $signed({1'b0, b_rgb[16-8*c +: 8]}) - $signed({1'b0, a_rgb[16-8*c +: 8]});
    always_ff @(posedge clk) begin
      prod_m[c] <= PW'(diff * $signed({1'b0, local_t}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else begin
      v_m <= v_q[PF+1];
    end
    abs_m <= abs_q[PF+1];
    a_m   <= a_rgb;
  end

  // rounding and output register
  logic [7:0] chan [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_round
    logic signed [AW-1:0] acc;
    assign acc = ($signed(AW'({1'b0, a_m[16-8*c +: 8]})) <<< PF) + AW'(prod_m[c])
                 + $signed(AW'(1) <<< (PF - 1));
    assign chan[c] = acc[PF+7:PF];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v_m;
    end
    if (abs_m) begin
      result <= '{red: absent_rgb[23:16], green: absent_rgb[15:8],
                  blue: absent_rgb[7:0], absent: 1'b1};
    end else begin
      result <= '{red: chan[0], green: chan[1], blue: chan[2], absent: 1'b0};
    end
  end

endmodule
`default_nettype wire

// ----- sim/log_scale_colour_ramp_check.sv -----
// checker: predicts the ramp colour of each request and compares the results
`timescale 1ns / 1ps
module log_scale_colour_ramp_check import lscr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  request_t         request,
  input  logic             result_valid,
  input  result_t          result,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output int               fail_count,
  output int               pending
);

  localparam int POS_BITS = 16;

  logic        usable;
  logic [31:0] low_fig;
  logic [31:0] high_fig;
  logic [23:0] stop_a;
  logic [23:0] stop_b;
  logic [23:0] stop_c;
  logic [23:0] absent_col;

  result_t colour_queue[$];

  function automatic longint unsigned log2_q24(input longint unsigned x);
    int unsigned top;
    longint unsigned y;
    longint unsigned m;
    longint unsigned frac;
    top = 0;
    y = x;
    frac = 0;
    while (y > 1) begin
      y = y >> 1;
      top++;
    end
    m = (top <= 31) ? (x << (31 - top)) : (x >> (top - 31));
    for (int i = 0; i < LOG_FRAC_BITS; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(top) << LOG_FRAC_BITS) | frac;
  endfunction

  function automatic longint unsigned ramp_pos(input longint unsigned s);
    longint unsigned lv, ll, lh, num, den;
    if (!(high_fig > low_fig)) return 0;
    lv = log2_q24(s);
    ll = log2_q24(low_fig);
    lh = log2_q24(high_fig);
    den = lh - ll;
    if (lv <= ll || den == 0) return 0;
    num = lv - ll;
    if (num >= den) return 64'd1 << POS_BITS;
    return ((num << (POS_BITS + 1)) + den) / (2 * den);
  endfunction

  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                     input longint unsigned frac);
    longint acc;
    acc = longint'(a) * (64'sd1 << POS_BITS) + (longint'(b) - longint'(a)) * longint'(frac);
    acc = acc + (64'sd1 << (POS_BITS - 1));
    return 8'((acc >>> POS_BITS) & 255);
  endfunction

  function automatic result_t paint_pixel(input request_t r);
    result_t c;
    longint unsigned t, frac;
    logic [23:0] a, b;
    if (!usable || !r.sigma_valid || r.sigma == 0 || low_fig == 0) begin
      c.red = absent_col[23:16];
      c.green = absent_col[15:8];
      c.blue = absent_col[7:0];
      c.absent = 1'b1;
      return c;
    end
    t = 2 * ramp_pos(r.sigma);
    if (t < (64'd1 << POS_BITS)) begin
      a = stop_a;
      b = stop_b;
      frac = t;
    end else begin
      a = stop_b;
      b = stop_c;
      frac = t - (64'd1 << POS_BITS);
    end
    c.red = mix(a[23:16], b[23:16], frac);
    c.green = mix(a[15:8], b[15:8], frac);
    c.blue = mix(a[7:0], b[7:0], frac);
    c.absent = 1'b0;
    return c;
  endfunction

  assign pending = colour_queue.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      usable <= 1'b0;
      low_fig <= 32'd1048576;
      high_fig <= 32'd1048576;
      stop_a <= '0;
      stop_b <= '0;
      stop_c <= '0;
      absent_col <= 24'd8421504;
      fail_count <= 0;
      colour_queue.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_SCALE_USABLE: usable <= wr_data[0];
          REG_LOW_PX: low_fig <= wr_data;
          REG_HIGH_PX: high_fig <= wr_data;
          REG_STOP_START: stop_a <= wr_data[23:0];
          REG_STOP_MIDDLE: stop_b <= wr_data[23:0];
          REG_STOP_END: stop_c <= wr_data[23:0];
          REG_ABSENT_RGB: absent_col <= wr_data[23:0];
          default: ;
        endcase
      end
      if (start && !busy) colour_queue = {colour_queue, paint_pixel(request)};
      if (result_valid) begin
        if (colour_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          want = colour_queue.pop_front();
          if (want.red !== result.red || want.green !== result.green ||
              want.blue !== result.blue || want.absent !== result.absent) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- sim/log_scale_colour_ramp_test.sv -----
// testbench top: stimulus, watchdog and verdict for the log scale colour ramp
`timescale 1ns / 1ps
module log_scale_colour_ramp_test;
  import lscr_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  request_t         request = '0;
  logic             result_valid;
  result_t          result;
  logic             wr_en = 1'b0;
  logic [2:0]       wr_index = '0;
  logic [CFG_W-1:0] wr_data = '0;
  int               fail_count;
  int               pending;
  int               idle_cycles = 0;

  always #5 clk = ~clk;

  log_scale_colour_ramp uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  log_scale_colour_ramp_check checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("log_scale_colour_ramp_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [31:0] s, input logic ok);
    start <= 1'b1;
    request <= '{sigma: s, sigma_valid: ok};
    do @(posedge clk); while (busy);
  endtask

  task automatic end_burst(input int gap);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sigma();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'd0;
      2: return 32'hFFFF_FFFF;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic load_scale(input logic [31:0] lo, input logic [31:0] hi);
    write_reg(REG_LOW_PX, lo);
    write_reg(REG_HIGH_PX, hi);
  endtask

  task automatic random_scale(input int kind);
    logic [31:0] lo;
    lo = $urandom >> $urandom_range(4, 31);
    case (kind)
      0: load_scale(32'd1, 32'hFFFF_FFFF);
      1: load_scale(lo, lo);
      2: load_scale(lo + 1, lo);
      3: load_scale(32'd0, 32'd1048576);
      4: load_scale(32'd1000000, 32'd1000001);
      default: load_scale(lo | 1, (lo | 1) << $urandom_range(1, 8));
    endcase
  endtask

  task automatic random_phase(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) begin
        send_pixel(rand_sigma(), $urandom_range(0, 7) != 0);
      end
      left -= burst;
      end_burst($urandom_range(1, 12));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset settings give the absent colour
    send_pixel(32'd1048576, 1'b1);
    send_pixel(32'd0, 1'b0);
    end_burst(1);
    settle();
    write_reg(REG_SCALE_USABLE, 32'd1);
    write_reg(REG_STOP_START, 32'h00_0000);
    write_reg(REG_STOP_MIDDLE, 32'h80_FF_40);
    write_reg(REG_STOP_END, 32'hFF_FF_FF);
    write_reg(REG_ABSENT_RGB, 32'h12_34_56);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    load_scale(32'h0001_0000, 32'h0100_0000);
    send_pixel(32'd0, 1'b1);
    send_pixel(32'h0008_0000, 1'b0);
    send_pixel(32'd1, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0001_0000, 1'b1);
    send_pixel(32'h0010_0000, 1'b1);
    send_pixel(32'h0040_0000, 1'b1);
    send_pixel(32'h0100_0000, 1'b1);
    send_pixel(32'h0001_0001, 1'b1);
    send_pixel(32'h00FF_FFFF, 1'b1);
    end_burst(1);
    settle();
    load_scale(32'h0010_0000, 32'h0010_0000);
    send_pixel(32'h0100_0000, 1'b1);
    end_burst(1);
    settle();
    load_scale(32'd0, 32'h0010_0000);
    send_pixel(32'h0100_0000, 1'b1);
    end_burst(1);
    settle();
    load_scale(32'd1000000, 32'd1000001);
    send_pixel(32'd2000000, 1'b1);
    send_pixel(32'd1000000, 1'b1);
    end_burst(1);
    settle();
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_SCALE_USABLE, (ph == 8) ? 32'd0 : 32'd1);
      random_scale(ph % 7);
      write_reg(REG_STOP_START, (ph == 1) ? 32'hFF_FFFF : $urandom & 24'hFF_FFFF);
      write_reg(REG_STOP_MIDDLE, (ph == 2) ? 32'd0 : $urandom & 24'hFF_FFFF);
      write_reg(REG_STOP_END, (ph == 3) ? 32'hFF_FFFF : $urandom & 24'hFF_FFFF);
      write_reg(REG_ABSENT_RGB, $urandom & 24'hFF_FFFF);
      random_phase(90);
      // hold off until the pipeline has drained
      if (ph == 4) settle();
      random_phase(90);
      settle();
    end
    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("log_scale_colour_ramp_test passed");
    end else begin
      $display("log_scale_colour_ramp_test failed");
    end
    $finish;
  end

endmodule
